### hw/rtl/lzss_token_decoder_macros.svh
// ----------------------------------------------------------------------------
// lzss_token_decoder_macros.svh
// Assertion macros for the LZSS token decoder; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef LZSS_TOKEN_DECODER_MACROS_SVH
`define LZSS_TOKEN_DECODER_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define LDEC_ASSERT_IMP(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("lzss_token_decoder: check failed");

// next-cycle implication
`define LDEC_ASSERT_NXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("lzss_token_decoder: check failed");

`else

`define LDEC_ASSERT_IMP(lbl, ck, rn, ante, cons)
`define LDEC_ASSERT_NXT(lbl, ck, rn, ante, cons)

`endif

`endif

### hw/rtl/ldec_pkg.sv
// ----------------------------------------------------------------------------
// ldec_pkg
// Shared types and fixed constants of the LZSS token decoder.
// ----------------------------------------------------------------------------
package ldec_pkg;

    // token queue between front and back
    localparam int FQ_DEPTH = 2;
    localparam int FQ_PTR_W = 1;
    localparam int FQ_CNT_W = 2;

    // result queue
    localparam int OQ_DEPTH = 4;
    localparam int OQ_PTR_W = 2;
    localparam int OQ_CNT_W = 3;

    typedef enum logic [1:0] {
        TK_LIT  = 2'd0,
        TK_COPY = 2'd1,
        TK_END  = 2'd2
    } tok_kind_t;

    typedef enum logic {
        BE_IDLE = 1'b0,
        BE_COPY = 1'b1
    } be_state_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       last_of_run;
        logic       stream_end;
    } result_t;

endpackage

### hw/rtl/ldec_front.sv
// ----------------------------------------------------------------------------
// ldec_front
// Accepts tokens, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
module ldec_front #(
    parameter int DICT_BITS   = 13,
    parameter int LENGTH_BITS = 4,
    parameter int MIN_MATCH   = 3
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    output logic                   full,
    input  logic                   cmd,
    input  logic [7:0]             literal,
    input  logic [LENGTH_BITS-1:0] length_code,
    input  logic [DICT_BITS-1:0]   distance,
    output logic                   tok_valid,
    input  logic                   tok_pop,
    output ldec_pkg::tok_kind_t    tok_kind,
    output logic [7:0]             tok_literal,
    output logic [LENGTH_BITS:0]   tok_count,
    output logic [DICT_BITS-1:0]   tok_distance
);
    import ldec_pkg::*;

    localparam int CNT_W = LENGTH_BITS + 1;

    tok_kind_t            kind_q  [FQ_DEPTH];
    logic [7:0]           lit_q   [FQ_DEPTH];
    logic [CNT_W-1:0]     count_q [FQ_DEPTH];
    logic [DICT_BITS-1:0] dist_q  [FQ_DEPTH];

    logic [FQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FQ_CNT_W-1:0] cnt_reg, cnt_next;

    tok_kind_t        in_kind;
    logic [CNT_W-1:0] in_count;
    logic             do_push;
    logic             do_pop;

    always_comb
    begin
        if (!cmd)
            in_kind = TK_LIT;
        else if (&length_code)
            in_kind = TK_END;
        else
            in_kind = TK_COPY;
        in_count = CNT_W'(length_code) + CNT_W'(MIN_MATCH);
    end

    assign full      = (cnt_reg == FQ_CNT_W'(FQ_DEPTH));
    assign tok_valid = (cnt_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = tok_pop && tok_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + FQ_CNT_W'(do_push) - FQ_CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            kind_q[wr_ptr_reg]  <= in_kind;
            lit_q[wr_ptr_reg]   <= literal;
            count_q[wr_ptr_reg] <= in_count;
            dist_q[wr_ptr_reg]  <= distance;
        end
    end

    assign tok_kind     = kind_q[rd_ptr_reg];
    assign tok_literal  = lit_q[rd_ptr_reg];
    assign tok_count    = count_q[rd_ptr_reg];
    assign tok_distance = dist_q[rd_ptr_reg];

endmodule

### hw/rtl/ldec_back.sv
// ----------------------------------------------------------------------------
// ldec_back
// Executes tokens on the circular dictionary, one byte per cycle while credit lasts.
// ----------------------------------------------------------------------------
module ldec_back #(
    parameter int DICT_BITS   = 13,
    parameter int LENGTH_BITS = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          tok_valid,
    output logic                          tok_pop,
    input  ldec_pkg::tok_kind_t           tok_kind,
    input  logic [7:0]                    tok_literal,
    input  logic [LENGTH_BITS:0]          tok_count,
    input  logic [DICT_BITS-1:0]          tok_distance,
    input  logic [ldec_pkg::OQ_CNT_W-1:0] oq_level,
    output logic                          res_push,
    output ldec_pkg::result_t             res_data,
    output logic                          busy
);
    import ldec_pkg::*;

    localparam int CNT_W     = LENGTH_BITS + 1;
    localparam int DICT_SIZE = 1 << DICT_BITS;

    // dictionary; never cleared, fill_reg masks unwritten entries as zero
    logic [7:0] dict_mem [DICT_SIZE];
    logic [7:0] rd_data_reg;

    be_state_t            state_reg, state_next;
    logic [DICT_BITS-1:0] wp_reg, wp_next;
    logic [DICT_BITS:0]   fill_reg, fill_next;
    logic [DICT_BITS-1:0] src_reg, src_next;
    logic [CNT_W-1:0]     remain_reg, remain_next;

    // issue stage
    logic                 can_issue;
    logic [OQ_CNT_W:0]    credit_sum;
    logic                 iss_vld;
    tok_kind_t            iss_kind;
    logic                 iss_last;
    logic [DICT_BITS-1:0] iss_addr;
    logic                 iss_fwd;
    logic                 iss_zero;

    // write/emit stage
    logic                 s2_valid_reg;
    tok_kind_t            s2_kind_reg;
    logic [7:0]           s2_lit_reg;
    logic [DICT_BITS-1:0] s2_wp_reg;
    logic                 s2_last_reg;
    logic                 s2_fwd_reg;
    logic                 s2_zero_reg;
    logic                 s2_wr;
    logic [7:0]           s2_data;
    logic [7:0]           last_wr_reg;

    // room for this issue plus the one already in flight
    assign credit_sum = {1'b0, oq_level} + (OQ_CNT_W + 1)'(s2_valid_reg);
    assign can_issue  = credit_sum < (OQ_CNT_W + 1)'(OQ_DEPTH);
    assign busy       = (state_reg == BE_COPY);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BE_IDLE:
            begin
                if (tok_valid && can_issue && tok_kind == TK_COPY)
                    state_next = BE_COPY;
            end
            BE_COPY:
            begin
                if (can_issue && remain_reg == CNT_W'(1))
                    state_next = BE_IDLE;
            end
            default: state_next = BE_IDLE;
        endcase
    end

    always_comb
    begin
        tok_pop  = 1'b0;
        iss_vld  = 1'b0;
        iss_kind = TK_LIT;
        iss_last = 1'b0;
        iss_addr = src_reg;
        unique case (state_reg)
            BE_IDLE:
            begin
                iss_addr = wp_reg - tok_distance;
                if (tok_valid && can_issue)
                begin
                    tok_pop  = 1'b1;
                    iss_vld  = 1'b1;
                    iss_kind = tok_kind;
                    iss_last = (tok_kind != TK_COPY);
                end
            end
            BE_COPY:
            begin
                if (can_issue)
                begin
                    iss_vld  = 1'b1;
                    iss_kind = TK_COPY;
                    iss_last = (remain_reg == CNT_W'(1));
                end
            end
            default: ;
        endcase
    end

    // source equal to the byte being written this cycle: take it from last_wr_reg
    assign iss_fwd  = s2_wr && (s2_wp_reg == iss_addr);
    assign iss_zero = {1'b0, iss_addr} >= fill_reg;

    always_comb
    begin
        wp_next     = wp_reg;
        src_next    = src_reg;
        remain_next = remain_reg;
        fill_next   = fill_reg;
        if (iss_vld)
        begin
            if (iss_kind == TK_END)
                wp_next = '0;
            else
                wp_next = wp_reg + 1'b1;
            if (iss_kind == TK_COPY)
                src_next = iss_addr + 1'b1;
        end
        if (iss_vld && iss_kind == TK_COPY)
        begin
            if (state_reg == BE_IDLE)
                remain_next = tok_count - CNT_W'(1);
            else
                remain_next = remain_reg - CNT_W'(1);
        end
        // writes run upward from zero, so the written region is [0, fill)
        if (s2_wr && {1'b0, s2_wp_reg} == fill_reg)
            fill_next = fill_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= BE_IDLE;
            wp_reg       <= '0;
            fill_reg     <= '0;
            remain_reg   <= '0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            wp_reg       <= wp_next;
            fill_reg     <= fill_next;
            remain_reg   <= remain_next;
            s2_valid_reg <= iss_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg     <= src_next;
        s2_kind_reg <= iss_kind;
        s2_lit_reg  <= tok_literal;
        s2_wp_reg   <= wp_reg;
        s2_last_reg <= iss_last;
        s2_fwd_reg  <= iss_fwd;
        s2_zero_reg <= iss_zero;
        if (s2_wr)
            last_wr_reg <= s2_data;
    end

    always_ff @(posedge clk)
    begin
        if (s2_wr)
            dict_mem[s2_wp_reg] <= s2_data;
        if (iss_vld && iss_kind == TK_COPY)
            rd_data_reg <= dict_mem[iss_addr];
    end

    assign s2_wr = s2_valid_reg && (s2_kind_reg != TK_END);

    always_comb
    begin
        case (s2_kind_reg)
            TK_LIT:  s2_data = s2_lit_reg;
            TK_COPY:
            begin
                if (s2_fwd_reg)
                    s2_data = last_wr_reg;
                else if (s2_zero_reg)
                    s2_data = 8'h00;
                else
                    s2_data = rd_data_reg;
            end
            default: s2_data = 8'h00;
        endcase
    end

    assign res_push             = s2_valid_reg;
    assign res_data.data_byte   = s2_data;
    assign res_data.byte_valid  = (s2_kind_reg != TK_END);
    assign res_data.last_of_run = s2_last_reg;
    assign res_data.stream_end  = (s2_kind_reg == TK_END);

endmodule

### hw/rtl/ldec_outq.sv
// ----------------------------------------------------------------------------
// ldec_outq
// Result queue; decouples the byte engine from the consumer.
// ----------------------------------------------------------------------------
module ldec_outq (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          res_push,
    input  ldec_pkg::result_t             res_data,
    output logic [ldec_pkg::OQ_CNT_W-1:0] oq_level,
    output logic                          oq_full,
    output logic                          empty,
    input  logic                          pop,
    output ldec_pkg::result_t             head
);
    import ldec_pkg::*;

    result_t             entry_q [OQ_DEPTH];
    logic [OQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [OQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [OQ_CNT_W-1:0] cnt_reg, cnt_next;
    logic                do_push;
    logic                do_pop;

    assign empty    = (cnt_reg == '0);
    assign oq_full  = (cnt_reg == OQ_CNT_W'(OQ_DEPTH));
    assign oq_level = cnt_reg;
    assign do_push  = res_push && !oq_full;
    assign do_pop   = pop && !empty;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + OQ_CNT_W'(do_push) - OQ_CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_q[wr_ptr_reg] <= res_data;
    end

    assign head = entry_q[rd_ptr_reg];

endmodule

### hw/rtl/lzss_token_decoder.sv
// ----------------------------------------------------------------------------
// lzss_token_decoder
// LZSS token decoder: literals and back-reference copies into a byte stream.
// ----------------------------------------------------------------------------
//  channel   direction  handshake     payload
//  token     in         push / full   cmd, literal, length_code, distance
//  result    out        empty / pop   data_byte, byte_valid, last_of_run,
//                                     stream_end
//
//  A literal or end marker yields one result; a match yields length_code +
//  MIN_MATCH bytes, one dictionary read and write each. A token goes through
//  the token queue, the issue stage (dictionary read) and the write stage, and
//  its results through the result queue. The dictionary is not swept at reset:
//  a fill counter makes never-written bytes read as zero. A 2-deep token queue
//  and a 4-deep result queue let either side stall.
// ----------------------------------------------------------------------------
`include "lzss_token_decoder_macros.svh"

module lzss_token_decoder #(
    parameter int DICT_BITS   = 13,
    parameter int LENGTH_BITS = 4,
    parameter int MIN_MATCH   = 3
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    output logic                   full,
    input  logic                   cmd,
    input  logic [7:0]             literal,
    input  logic [LENGTH_BITS-1:0] length_code,
    input  logic [DICT_BITS-1:0]   distance,
    output logic                   empty,
    input  logic                   pop,
    output logic [7:0]             data_byte,
    output logic                   byte_valid,
    output logic                   last_of_run,
    output logic                   stream_end
);
    import ldec_pkg::*;

    logic                 tok_valid;
    logic                 tok_pop;
    tok_kind_t            tok_kind;
    logic [7:0]           tok_literal;
    logic [LENGTH_BITS:0] tok_count;
    logic [DICT_BITS-1:0] tok_distance;
    logic [OQ_CNT_W-1:0]  oq_level;
    logic                 oq_full;
    logic                 res_push;
    result_t              res_data;
    result_t              head;
    logic                 busy;

    ldec_front #(
        .DICT_BITS   (DICT_BITS),
        .LENGTH_BITS (LENGTH_BITS),
        .MIN_MATCH   (MIN_MATCH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .cmd          (cmd),
        .literal      (literal),
        .length_code  (length_code),
        .distance     (distance),
        .tok_valid    (tok_valid),
        .tok_pop      (tok_pop),
        .tok_kind     (tok_kind),
        .tok_literal  (tok_literal),
        .tok_count    (tok_count),
        .tok_distance (tok_distance)
    );

    ldec_back #(
        .DICT_BITS   (DICT_BITS),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .tok_valid    (tok_valid),
        .tok_pop      (tok_pop),
        .tok_kind     (tok_kind),
        .tok_literal  (tok_literal),
        .tok_count    (tok_count),
        .tok_distance (tok_distance),
        .oq_level     (oq_level),
        .res_push     (res_push),
        .res_data     (res_data),
        .busy         (busy)
    );

    ldec_outq u_outq (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_push (res_push),
        .res_data (res_data),
        .oq_level (oq_level),
        .oq_full  (oq_full),
        .empty    (empty),
        .pop      (pop),
        .head     (head)
    );

    assign data_byte   = head.data_byte;
    assign byte_valid  = head.byte_valid;
    assign last_of_run = head.last_of_run;
    assign stream_end  = head.stream_end;

    // engine credit must keep the result queue from overflowing
    `LDEC_ASSERT_IMP(a_oq_no_overflow, clk, rst_n, res_push, !oq_full)
    // a new token is taken only between copies
    `LDEC_ASSERT_IMP(a_pop_when_idle, clk, rst_n, tok_pop, tok_valid && !busy)
    // end marker result carries no byte
    `LDEC_ASSERT_IMP(a_end_result, clk, rst_n, !empty && stream_end,
        !byte_valid && last_of_run && data_byte == 8'h00)

endmodule
